[rtl/assert_macros.svh]
// Assertion macros for the RTL file that checks its own logic, the top level.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define GBCI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gbci assertion failed");

// Next-cycle implication, disabled while reset is low
`define GBCI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gbci assertion failed");

`endif

[rtl/gbci_pkg.sv]
// Package for the gyro bias calibration and angle integration block.
// Field widths, reset values, register map and shared types. No dependencies.
package gbci_pkg;

    localparam int SAMPLES_DEF = 256;   // samples per calibration run
    localparam int SAMPLE_W    = 16;
    localparam int DRIFT_W     = 24;    // Q16.8
    localparam int FRAC_W      = 8;     // fractional bits of the drift
    localparam int ANGLE_W     = 64;    // Q32.32
    localparam int GAIN_W      = 32;    // Q8.24
    localparam int DZ_W        = SAMPLE_W + FRAC_W + 1;
    localparam int PROD_W      = DZ_W + GAIN_W + 1;
    localparam int APB_ADDR_W  = 2;
    localparam int APB_DATA_W  = 32;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 32'd1024;

    // Register map (word index)
    localparam logic [APB_ADDR_W-1:0] REG_GAIN_ADDR = 2'd0;

    // Input modes
    localparam logic MODE_CALIBRATE = 1'b0;
    localparam logic MODE_INTEGRATE = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [DRIFT_W-1:0]  t_drift;
    typedef logic signed [ANGLE_W-1:0]  t_angle;

    // Handshake with the mean unit
    typedef struct packed {
        logic start;   // finishing item waiting for its mean
        logic take;    // finishing item leaves, result consumed
    } t_mean_ctl;

endpackage

[rtl/gbci_if.sv]
// Valid/ready channel interfaces for samples in and results out.
// Depends on gbci_pkg.
interface gbci_in_if;
    logic              valid;
    logic              ready;
    logic              mode;
    gbci_pkg::t_sample rate_sample;

    modport source (output valid, output mode, output rate_sample, input ready);
    modport sink   (input valid, input mode, input rate_sample, output ready);
endinterface

interface gbci_out_if;
    logic              valid;
    logic              ready;
    gbci_pkg::t_angle  angle;
    gbci_pkg::t_angle  previous_angle;
    gbci_pkg::t_drift  drift;
    logic              calibrated;

    modport source (output valid, output angle, output previous_angle, output drift,
                    output calibrated, input ready);
    modport sink   (input valid, input angle, input previous_angle, input drift,
                    input calibrated, output ready);
endinterface

[rtl/gyro_bias_calibrate_and_integrate.sv]
// Top level: gyro rate bias calibration and saturating angle integration.
// Depends on gbci_pkg, gbci_if.sv, gbci_mean and assert_macros.svh.
//
//  Channel        Direction  Transaction contents
//  i_sample_if    in         mode, rate_sample
//  o_result_if    out        angle, previous_angle, drift, calibrated
//  APB (psel...)  in/out     gain register at byte address 0
//
//  One transaction per cycle while neither the result side nor the mean unit stalls;
//  a result passes through the input, product and result registers.
//  A finishing calibrate item takes its mean in the same cycle when SAMPLES is a
//  power of two; otherwise the reciprocal multiply holds it in the input register
//  until the mean is ready, one 16-bit slice per cycle.
//  Synchronous active-low reset clears the valid flags, calibration and angle state; the gain returns to 1024.
//  Backpressure on the result side stalls each stage only while it is full.
module gyro_bias_calibrate_and_integrate #(
    parameter int SAMPLES = gbci_pkg::SAMPLES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    gbci_in_if.sink                              i_sample_if,
    gbci_out_if.source                           o_result_if,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [gbci_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [gbci_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [gbci_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);

`include "assert_macros.svh"

    localparam int SUM_W = gbci_pkg::SAMPLE_W + $clog2(SAMPLES) + 1;
    localparam int CNT_W = $clog2(SAMPLES + 1);

    // Configuration register
    logic [gbci_pkg::GAIN_W-1:0] r_gain;

    assign pready = 1'b1;
    assign prdata = r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= gbci_pkg::GAIN_RESET;
        end else if (psel && penable && pwrite && paddr == gbci_pkg::REG_GAIN_ADDR) begin
            r_gain <= pwdata;
        end
    end

    // Pipeline registers
    logic                           r_a_valid, r_b_valid, r_c_valid;
    logic                           r_a_mode, r_b_mode;
    gbci_pkg::t_sample              r_a_sample;
    logic signed [gbci_pkg::PROD_W-1:0] r_b_prod;
    gbci_pkg::t_drift               r_b_bias;
    logic                           r_b_done;

    // Calibration state
    logic signed [SUM_W-1:0]        r_sum, n_sum;
    logic [CNT_W-1:0]               r_count, n_count;
    gbci_pkg::t_drift               r_bias, n_bias;
    logic                           r_done_flag, n_done_flag;

    // Result register, also the angle state
    gbci_pkg::t_angle               r_c_angle, n_c_angle;
    gbci_pkg::t_angle               r_c_prev, n_c_prev;
    gbci_pkg::t_drift               r_c_drift;
    logic                           r_c_cal;

    logic                           c_ready, b_ready, adv_ab, adv_bc, a_take;
    logic                           finishing;
    gbci_pkg::t_mean_ctl            mean_ctl;
    logic                           mean_valid;
    gbci_pkg::t_drift               mean_q;

    // Stage flow control
    assign finishing = r_a_valid && r_a_mode == gbci_pkg::MODE_CALIBRATE
                       && r_count >= CNT_W'(SAMPLES);
    assign c_ready   = !r_c_valid || o_result_if.ready;
    assign b_ready   = !r_b_valid || c_ready;
    assign adv_ab    = r_a_valid && b_ready && (!finishing || mean_valid);
    assign adv_bc    = r_b_valid && c_ready;
    assign a_take    = i_sample_if.valid && i_sample_if.ready;
    assign i_sample_if.ready = !r_a_valid || adv_ab;

    assign mean_ctl.start = finishing;
    assign mean_ctl.take  = adv_ab && finishing;

    gbci_mean #(
        .SAMPLES (SAMPLES),
        .SUM_W   (SUM_W)
    ) u_mean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mean_ctl),
        .i_sum   (r_sum),
        .o_valid (mean_valid),
        .o_mean  (mean_q)
    );

    // Calibration update as an item leaves the input register
    always_comb begin
        n_sum       = r_sum;
        n_count     = r_count;
        n_bias      = r_bias;
        n_done_flag = r_done_flag;
        if (adv_ab && r_a_mode == gbci_pkg::MODE_CALIBRATE) begin
            if (finishing) begin
                n_bias      = mean_q;
                n_sum       = '0;
                n_count     = '0;
                n_done_flag = 1'b1;
            end else begin
                n_sum   = r_sum + SUM_W'(r_a_sample);
                n_count = r_count + 1'b1;
            end
        end
    end

    // Rate increment: (sample * 256 - drift) * gain
    logic signed [gbci_pkg::DZ_W-1:0]   dz;
    logic signed [gbci_pkg::PROD_W-1:0] prod;
    assign dz   = $signed({r_a_sample, {gbci_pkg::FRAC_W{1'b0}}})
                  - $signed({r_bias[gbci_pkg::DRIFT_W-1], r_bias});
    assign prod = dz * $signed({1'b0, r_gain});

    // Saturating accumulate as an integrate item enters the result register
    logic signed [gbci_pkg::ANGLE_W:0] sum_ext;
    assign sum_ext = {r_c_angle[gbci_pkg::ANGLE_W-1], r_c_angle}
                     + (gbci_pkg::ANGLE_W + 1)'(r_b_prod);

    always_comb begin
        n_c_angle = r_c_angle;
        n_c_prev  = r_c_prev;
        if (r_b_mode == gbci_pkg::MODE_INTEGRATE) begin
            n_c_prev = r_c_angle;
            if (sum_ext[gbci_pkg::ANGLE_W] != sum_ext[gbci_pkg::ANGLE_W-1]) begin
                n_c_angle = sum_ext[gbci_pkg::ANGLE_W]
                            ? {1'b1, {(gbci_pkg::ANGLE_W-1){1'b0}}}
                            : {1'b0, {(gbci_pkg::ANGLE_W-1){1'b1}}};
            end else begin
                n_c_angle = sum_ext[gbci_pkg::ANGLE_W-1:0];
            end
        end
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_sum       <= '0;
            r_count     <= '0;
            r_bias      <= '0;
            r_done_flag <= 1'b0;
            r_c_angle   <= '0;
            r_c_prev    <= '0;
        end else begin
            r_sum       <= n_sum;
            r_count     <= n_count;
            r_bias      <= n_bias;
            r_done_flag <= n_done_flag;
            if (i_sample_if.ready) begin
                r_a_valid <= i_sample_if.valid;
            end
            if (b_ready) begin
                r_b_valid <= adv_ab;
            end
            if (c_ready) begin
                r_c_valid <= r_b_valid;
            end
            if (adv_bc) begin
                r_c_angle <= n_c_angle;
                r_c_prev  <= n_c_prev;
            end
        end
        if (a_take) begin
            r_a_mode   <= i_sample_if.mode;
            r_a_sample <= i_sample_if.rate_sample;
        end
        if (adv_ab) begin
            r_b_mode <= r_a_mode;
            r_b_prod <= prod;
            r_b_bias <= n_bias;
            r_b_done <= n_done_flag;
        end
        if (adv_bc) begin
            r_c_drift <= r_b_bias;
            r_c_cal   <= r_b_done;
        end
    end

    assign o_result_if.valid          = r_c_valid;
    assign o_result_if.angle          = r_c_angle;
    assign o_result_if.previous_angle = r_c_prev;
    assign o_result_if.drift          = r_c_drift;
    assign o_result_if.calibrated     = r_c_cal;

    // Checks
    logic cal_cleared;
    logic cal_bc;
    assign cal_cleared = r_count == '0 && r_sum == '0 && r_done_flag;
    assign cal_bc      = adv_bc && r_b_mode == gbci_pkg::MODE_CALIBRATE;

    `GBCI_ASSERT_NEXT(a_finish_clears, i_clk, i_rst_n, adv_ab && finishing, cal_cleared)
    `GBCI_ASSERT_NEXT(a_cal_keeps_angle, i_clk, i_rst_n, cal_bc, $stable({r_c_angle, r_c_prev}))
    `GBCI_ASSERT_NOW(a_done_sticky, i_clk, i_rst_n, 1'b1, !$fell(r_done_flag))

endmodule

[rtl/gbci_mean.sv]
// Floor mean of the calibration sum in Q.8: sum * 256 / SAMPLES, rounded down.
// Power-of-two sample counts use a shift, others a reciprocal multiply done slice by slice.
// Depends on gbci_pkg.
module gbci_mean #(
    parameter int SAMPLES = gbci_pkg::SAMPLES_DEF,
    parameter int SUM_W   = gbci_pkg::SAMPLE_W + $clog2(SAMPLES) + 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  gbci_pkg::t_mean_ctl    i_ctl,
    input  logic signed [SUM_W-1:0] i_sum,
    output logic                   o_valid,
    output gbci_pkg::t_drift       o_mean
);

    localparam int  NUM_W   = SUM_W + gbci_pkg::FRAC_W;
    localparam bit  IS_POW2 = (SAMPLES & (SAMPLES - 1)) == 0;

    logic signed [NUM_W-1:0] num;
    assign num = {i_sum, {gbci_pkg::FRAC_W{1'b0}}};

    if (IS_POW2) begin : g_shift
        localparam int SHIFT = $clog2(SAMPLES);
        logic signed [NUM_W-1:0] quot;

        // arithmetic shift is the floor division
        assign quot    = num >>> SHIFT;
        assign o_valid = i_ctl.start;
        assign o_mean  = quot[gbci_pkg::DRIFT_W-1:0];
    end else begin : g_div
        // q = (x * RCP) >> SHIFT_R is exact for every x below 2^NUM_W
        localparam int LOG_N   = $clog2(SAMPLES);
        localparam int SHIFT_R = NUM_W + LOG_N;
        localparam int RCP_W   = NUM_W + 1;
        localparam int SLICE_W = 16;
        localparam int SLICES  = (RCP_W + SLICE_W - 1) / SLICE_W;
        localparam int RCP_PW  = SLICES * SLICE_W;
        localparam int ACC_W   = NUM_W + RCP_PW;
        localparam int CNT_W   = $clog2(SLICES + 1);
        localparam logic [63:0] RCP_FULL =
            ((64'd1 << SHIFT_R) + 64'(SAMPLES - 1)) / 64'(SAMPLES);
        localparam logic [RCP_PW-1:0] RCP = RCP_PW'(RCP_FULL);

        logic                          r_busy, n_busy;
        logic                          r_valid, n_valid;
        logic                          r_neg, n_neg;
        logic [NUM_W-1:0]              r_x, n_x;
        logic [RCP_PW-1:0]             r_m, n_m;
        logic [ACC_W-1:0]              r_acc, n_acc;
        logic [CNT_W-1:0]              r_cnt, n_cnt;
        logic [NUM_W-1:0]              x_abs;
        logic [NUM_W+SLICE_W-1:0]      part;
        logic [gbci_pkg::DRIFT_W-1:0]  q_mag;

        // negative sums divide -num + N - 1, then negate
        assign x_abs = num[NUM_W-1] ? $unsigned(-num) + NUM_W'(SAMPLES - 1)
                                    : $unsigned(num);
        // one 16-bit slice of the reciprocal per cycle, top slice first
        assign part  = r_x * r_m[RCP_PW-1 -: SLICE_W];

        always_comb begin
            n_busy  = r_busy;
            n_valid = r_valid;
            n_neg   = r_neg;
            n_x     = r_x;
            n_m     = r_m;
            n_acc   = r_acc;
            n_cnt   = r_cnt;
            if (r_busy) begin
                n_acc = {r_acc[ACC_W-SLICE_W-1:0], {SLICE_W{1'b0}}} + ACC_W'(part);
                n_m   = {r_m[RCP_PW-SLICE_W-1:0], {SLICE_W{1'b0}}};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_busy  = 1'b0;
                    n_valid = 1'b1;
                end
            end else if (r_valid) begin
                if (i_ctl.take) begin
                    n_valid = 1'b0;
                end
            end else if (i_ctl.start) begin
                n_busy = 1'b1;
                n_neg  = num[NUM_W-1];
                n_x    = x_abs;
                n_m    = RCP;
                n_acc  = '0;
                n_cnt  = CNT_W'(SLICES);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_busy  <= 1'b0;
                r_valid <= 1'b0;
            end else begin
                r_busy  <= n_busy;
                r_valid <= n_valid;
            end
            r_neg <= n_neg;
            r_x   <= n_x;
            r_m   <= n_m;
            r_acc <= n_acc;
            r_cnt <= n_cnt;
        end

        assign q_mag   = r_acc[SHIFT_R +: gbci_pkg::DRIFT_W];
        assign o_valid = r_valid;
        assign o_mean  = r_neg ? -q_mag : q_mag;
    end

endmodule

[bench/gbci_result_checker.sv]
`timescale 1ns / 100ps
// Result checker for the gyro bias calibration and angle integration block.
// Watches the sample, result and APB ports, predicts every result and compares.
// Depends on gbci_pkg and the channel interfaces in gbci_if.sv.
module gbci_result_checker #(
    parameter int SAMPLES = gbci_pkg::SAMPLES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    gbci_in_if                              i_sample_if,
    gbci_out_if                             i_result_if,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [gbci_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [gbci_pkg::APB_DATA_W-1:0] i_pwdata,
    input  logic [gbci_pkg::APB_DATA_W-1:0] i_prdata,
    input  logic                            i_pready,
    output int                              o_pending,
    output int                              o_fail_count
);
    import gbci_pkg::*;

    localparam int REPORT_CAP = 200;

    typedef struct {
        t_angle angle;
        t_angle previous_angle;
        t_drift drift;
        logic   calibrated;
    } rate_result_t;

    // Predicted state of the block
    logic [GAIN_W-1:0] gain_q24;
    longint            run_sum;
    int                run_count;
    t_drift            bias_q8;
    logic              cal_done;
    t_angle            angle_now;
    t_angle            angle_last;

    rate_result_t      expected_q[$];
    int                fails;

    // Floor of the run mean, in Q16.8
    function automatic t_drift mean_q8(input longint total);
        longint num;
        longint quo;
        num = total * 256;
        quo = num / SAMPLES;
        if ((num % SAMPLES) != 0 && num < 0)
            quo = quo - 1;
        return quo[DRIFT_W-1:0];
    endfunction

    // Signed 64-bit add that clamps at the limits
    function automatic t_angle sat_add(input t_angle acc, input longint step);
        logic [ANGLE_W:0] wide;
        wide = {acc[ANGLE_W-1], acc} + {step[63], step};
        if (wide[ANGLE_W] != wide[ANGLE_W-1])
            return wide[ANGLE_W] ? {1'b1, {(ANGLE_W-1){1'b0}}} : {1'b0, {(ANGLE_W-1){1'b1}}};
        return wide[ANGLE_W-1:0];
    endfunction

    // Advance the predicted state by one sample and queue the result it gives
    task automatic advance_gyro(input logic mode, input t_sample rate);
        longint dz;
        longint inc;
        if (mode == MODE_CALIBRATE) begin
            if (run_count < SAMPLES) begin
                run_sum   = run_sum + longint'(rate);
                run_count = run_count + 1;
            end else begin
                // end of run: sample ignored, mean becomes the drift
                bias_q8   = mean_q8(run_sum);
                run_sum   = 0;
                run_count = 0;
                cal_done  = 1'b1;
            end
        end else begin
            dz         = longint'(rate) * 256 - longint'(bias_q8);
            inc        = dz * longint'({32'd0, gain_q24});
            angle_last = angle_now;
            angle_now  = sat_add(angle_now, inc);
        end
        expected_q.push_back('{angle_now, angle_last, bias_q8, cal_done});
    endtask

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        fails = fails + 1;
        if (fails <= REPORT_CAP)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    endtask

    // Compare one result transaction with the oldest expectation
    task automatic check_result();
        rate_result_t want;
        if (expected_q.size() == 0) begin
            fails = fails + 1;
            if (fails <= REPORT_CAP)
                $display("%0t: result with nothing expected, expected none, actual angle %h",
                         $time, i_result_if.angle);
        end else begin
            want = expected_q.pop_front();
            if (i_result_if.angle !== want.angle)
                note_mismatch("angle", want.angle, i_result_if.angle);
            if (i_result_if.previous_angle !== want.previous_angle)
                note_mismatch("previous_angle", want.previous_angle,
                              i_result_if.previous_angle);
            if (i_result_if.drift !== want.drift)
                note_mismatch("drift", 64'(want.drift), 64'(i_result_if.drift));
            if (i_result_if.calibrated !== want.calibrated)
                note_mismatch("calibrated", 64'(want.calibrated), 64'(i_result_if.calibrated));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gain_q24   = GAIN_RESET;
            run_sum    = 0;
            run_count  = 0;
            bias_q8    = '0;
            cal_done   = 1'b0;
            angle_now  = '0;
            angle_last = '0;
            fails      = 0;
            expected_q.delete();
        end else begin
            // register access
            if (i_psel === 1'b1 && i_penable === 1'b1 && i_pready === 1'b1
                    && i_paddr == REG_GAIN_ADDR) begin
                if (i_pwrite)
                    gain_q24 = i_pwdata;
                else if (i_prdata !== gain_q24)
                    note_mismatch("gain read-back", 64'(gain_q24), 64'(i_prdata));
            end
            // push before pop, so a same-edge result still finds its expectation
            if (i_sample_if.valid === 1'b1 && i_sample_if.ready === 1'b1)
                advance_gyro(i_sample_if.mode, i_sample_if.rate_sample);
            if (i_result_if.valid === 1'b1 && i_result_if.ready === 1'b1)
                check_result();
        end
        o_pending    <= expected_q.size();
        o_fail_count <= fails;
    end

endmodule

[bench/gyro_bias_calibrate_and_integrate_test.sv]
`timescale 1ns / 100ps
// Testbench top: drives samples, gain writes and result back-pressure, gives the verdict.
// Depends on gbci_pkg, gbci_if.sv, the block and gbci_result_checker.
module gyro_bias_calibrate_and_integrate_test;
    import gbci_pkg::*;

    localparam int     SAMPLES    = SAMPLES_DEF;
    localparam int     IDLE_LIMIT = 2000;
    localparam int     DRAIN_WAIT = 12;
    localparam t_sample RATE_MAX  = 16'h7FFF;
    localparam t_sample RATE_MIN  = 16'h8000;

    typedef enum int {
        RATE_RANDOM,
        RATE_TOP,
        RATE_BOTTOM,
        RATE_NEAR_TOP,
        RATE_NEAR_BOTTOM,
        RATE_BIASED
    } rate_style_e;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int pending;
    int fail_count;
    int idle_cycles = 0;
    int stall_left  = 0;
    int cal_in_run;
    int rate_base;
    bit quiet_phase;

    gbci_in_if  sample_ch ();
    gbci_out_if result_ch ();

    gyro_bias_calibrate_and_integrate #(
        .SAMPLES (SAMPLES)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_sample_if (sample_ch),
        .o_result_if (result_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    gbci_result_checker #(
        .SAMPLES (SAMPLES)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_sample_if  (sample_ch),
        .i_result_if  (result_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Idle length: mostly short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 2);
        if (r < 95)
            return $urandom_range(3, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int input_gap();
        if (quiet_phase || $urandom_range(0, 1) == 0)
            return 0;
        return idle_len();
    endfunction

    function automatic t_sample pick_rate(input rate_style_e style);
        case (style)
            RATE_TOP:         return RATE_MAX;
            RATE_BOTTOM:      return RATE_MIN;
            RATE_NEAR_TOP:    return t_sample'($urandom_range(32500, 32767));
            RATE_NEAR_BOTTOM: return t_sample'(int'(RATE_MIN) + int'($urandom_range(0, 268)));
            RATE_BIASED:      return t_sample'(rate_base + int'($urandom_range(0, 400)) - 200);
            default:          return t_sample'($urandom);
        endcase
    endfunction

    // Result side back-pressure
    always @(posedge clk) begin
        if (!rst_n || quiet_phase) begin
            result_ch.ready <= 1'b1;
            stall_left      <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < 60) begin
            result_ch.ready <= 1'b1;
            stall_left      <= $urandom_range(0, 8);
        end else begin
            result_ch.ready <= 1'b0;
            stall_left      <= idle_len();
        end
    end

    // Watchdog: cycles without any transaction on either channel
    always @(posedge clk) begin
        if ((sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1)
                || (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("** gyro_bias_calibrate_and_integrate: FAILED **");
            $finish;
        end
    end

    // One sample transaction; returns at the edge where it is taken
    task automatic send_item(input logic mode, input t_sample rate);
        int gap;
        gap = input_gap();
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.mode        <= mode;
        sample_ch.rate_sample <= rate;
        do @(posedge clk); while (sample_ch.ready !== 1'b1);
        if (mode == MODE_CALIBRATE)
            cal_in_run = (cal_in_run < SAMPLES) ? cal_in_run + 1 : 0;
    endtask

    // Fill the current run, with integrate samples mixed in, then finish it
    task automatic calibration_run(input rate_style_e style, input int integrate_pct);
        while (cal_in_run < SAMPLES) begin
            if ($urandom_range(0, 99) < integrate_pct)
                send_item(MODE_INTEGRATE, pick_rate(RATE_RANDOM));
            else
                send_item(MODE_CALIBRATE, pick_rate(style));
        end
        send_item(MODE_CALIBRATE, pick_rate(RATE_RANDOM));
    endtask

    task automatic integrate_burst(input rate_style_e style, input int count);
        repeat (count) send_item(MODE_INTEGRATE, pick_rate(style));
    endtask

    // APB setup then access phase on the gain register
    task automatic gain_access(input logic wr, input logic [APB_DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= REG_GAIN_ADDR;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Drain the block, then write the gain and read it back
    task automatic set_gain(input logic [APB_DATA_W-1:0] value);
        sample_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        gain_access(1'b1, value);
        gain_access(1'b0, '0);
    endtask

    initial begin
        rst_n                 = 1'b0;
        quiet_phase           = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        sample_ch.valid       = 1'b0;
        sample_ch.mode        = MODE_CALIBRATE;
        sample_ch.rate_sample = '0;
        result_ch.ready       = 1'b0;
        cal_in_run            = 0;
        rate_base             = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // gain reset value, integration before any calibration (zero drift)
        gain_access(1'b0, '0);
        send_item(MODE_INTEGRATE, RATE_MAX);
        send_item(MODE_INTEGRATE, RATE_MIN);
        send_item(MODE_INTEGRATE, '0);
        send_item(MODE_INTEGRATE, 16'hFFFF);
        send_item(MODE_INTEGRATE, 16'h5555);
        // extremes into a fresh run, with an integrate sample in the middle
        send_item(MODE_CALIBRATE, RATE_MAX);
        send_item(MODE_CALIBRATE, RATE_MIN);
        send_item(MODE_CALIBRATE, 16'hAAAA);
        send_item(MODE_CALIBRATE, '0);
        send_item(MODE_INTEGRATE, 16'h0001);
        // gain extremes
        set_gain('0);
        send_item(MODE_INTEGRATE, RATE_MAX);
        send_item(MODE_INTEGRATE, RATE_MIN);
        set_gain('1);
        send_item(MODE_INTEGRATE, 16'h0001);
        send_item(MODE_INTEGRATE, 16'hFFFF);
        send_item(MODE_INTEGRATE, RATE_MIN);
        send_item(MODE_CALIBRATE, RATE_MAX);
        set_gain(32'd1);
        send_item(MODE_INTEGRATE, RATE_MAX);

        // finish the open run with random content, no idling on either side
        quiet_phase <= 1'b1;
        set_gain($urandom);
        calibration_run(RATE_RANDOM, 15);
        integrate_burst(RATE_RANDOM, 30);
        quiet_phase <= 1'b0;

        // highest drift, then full gain down into negative saturation
        set_gain(GAIN_RESET);
        calibration_run(RATE_TOP, 5);
        set_gain('1);
        integrate_burst(RATE_NEAR_BOTTOM, 280);

        // lowest drift, then up into positive saturation; this run replaces the drift
        calibration_run(RATE_BOTTOM, 5);
        integrate_burst(RATE_NEAR_TOP, 280);

        // realistic sensor: small offset plus noise, modest gain
        rate_base = int'($urandom_range(0, 6000)) - 3000;
        set_gain($urandom_range(0, 32'h00FF_FFFF));
        calibration_run(RATE_BIASED, 20);
        integrate_burst(RATE_BIASED, 15);
        integrate_burst(RATE_RANDOM, 15);

        // wait for every result, then the tail
        sample_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("** gyro_bias_calibrate_and_integrate: PASSED **");
        else
            $display("** gyro_bias_calibrate_and_integrate: FAILED **");
        $finish;
    end

endmodule
